>>> rtl/mcirq_pkg.sv
// ----------------------------------------------------------------------------
// mcirq_pkg
// Shared types and constants for the multicart mapper, IRQ and bank logic.
// ----------------------------------------------------------------------------
`default_nettype none

package mcirq_pkg;

  // Command codes carried in the cmd field; the fourth code does nothing
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // Address decode
  localparam logic [15:0] DECODE_MASK = 16'hF1FF;
  localparam logic [15:0] ADDR_BANK   = 16'h4022;
  localparam logic [15:0] ADDR_CTRL   = 16'h4122;

  // Status byte returned on a control read
  localparam logic [7:0] STATUS_BASE = 8'h8A;
  localparam logic [7:0] STATUS_MASK = 8'h35;

  // Interrupt counter
  localparam int unsigned IRQ_PERIOD = 4096;
  localparam int unsigned COUNTER_W  = 13;

  // Switchable window at 0xC000; other windows are fixed wiring
  // (0x6000 = 2, 0x8000 = 1, 0xA000 = 0, 0xE000 = 8)
  localparam logic [3:0] BANK_TABLE [8] = '{
    4'd4, 4'd3, 4'd5, 4'd3, 4'd6, 4'd3, 4'd7, 4'd3
  };

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  cycles;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       rdata_valid;
    logic       irq;
    logic [3:0] bank_c000;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/mcirq_if.sv
// ----------------------------------------------------------------------------
// mcirq_if
// Valid/ready channels for bus items and mapper results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcirq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [7:0]  cycles;

  modport source (output valid, cmd, addr, wdata, cycles, input ready);
  modport sink   (input valid, cmd, addr, wdata, cycles, output ready);
endinterface

interface mcirq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       rdata_valid;
  logic       irq;
  logic [3:0] bank_c000;

  modport source (output valid, rdata, rdata_valid, irq, bank_c000, input ready);
  modport sink   (input valid, rdata, rdata_valid, irq, bank_c000, output ready);
endinterface

`default_nettype wire

>>> rtl/mcirq_core.sv
// ----------------------------------------------------------------------------
// mcirq_core
// Mapper state (latches, cycle counter, IRQ) and single-pass item decode.
// ----------------------------------------------------------------------------
`default_nettype none

module mcirq_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire mcirq_pkg::item_t   item,
  output      mcirq_pkg::result_t result
);
  import mcirq_pkg::*;

  logic [2:0]           bank_latch,    bank_latch_next;
  logic [7:0]           control_latch, control_latch_next;
  logic                 irq_enable,    irq_enable_next;
  logic [COUNTER_W-1:0] cycle_counter, cycle_counter_next;
  logic                 irq_pending,   irq_pending_next;

  logic [15:0]          decoded;
  logic [COUNTER_W:0]   sum;

  always_comb begin
    decoded            = item.addr & DECODE_MASK;
    sum                = {1'b0, cycle_counter} + (COUNTER_W + 1)'(item.cycles);
    bank_latch_next    = bank_latch;
    control_latch_next = control_latch;
    irq_enable_next    = irq_enable;
    cycle_counter_next = cycle_counter;
    irq_pending_next   = irq_pending;
    result.rdata       = '0;
    result.rdata_valid = 1'b0;

    case (item.cmd)
      CMD_WRITE: begin
        if (decoded == ADDR_BANK) begin
          bank_latch_next = item.wdata[2:0];
        end else if (decoded == ADDR_CTRL) begin
          control_latch_next = item.wdata;
          irq_enable_next    = item.wdata[0];
          // clearing the enable also acknowledges the IRQ
          if (!item.wdata[0]) begin
            cycle_counter_next = '0;
            irq_pending_next   = 1'b0;
          end
        end
      end
      CMD_READ: begin
        if (decoded == ADDR_CTRL) begin
          result.rdata       = STATUS_BASE | (control_latch & STATUS_MASK);
          result.rdata_valid = 1'b1;
        end
      end
      CMD_TICK: begin
        if (irq_enable) begin
          // at most one wrap per tick: cycles is always below the period
          if (sum >= (COUNTER_W + 1)'(IRQ_PERIOD)) begin
            cycle_counter_next = COUNTER_W'(sum - (COUNTER_W + 1)'(IRQ_PERIOD));
            irq_pending_next   = 1'b1;
          end else begin
            cycle_counter_next = COUNTER_W'(sum);
          end
        end
      end
      default: begin
      end
    endcase

    result.irq       = irq_pending_next;
    result.bank_c000 = BANK_TABLE[bank_latch_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_latch    <= '0;
      control_latch <= '0;
      irq_enable    <= 1'b0;
      cycle_counter <= '0;
      irq_pending   <= 1'b0;
    end else if (fire) begin
      bank_latch    <= bank_latch_next;
      control_latch <= control_latch_next;
      irq_enable    <= irq_enable_next;
      cycle_counter <= cycle_counter_next;
      irq_pending   <= irq_pending_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_counter_below_period: assert property (@(posedge clk) disable iff (rst)
    cycle_counter < COUNTER_W'(IRQ_PERIOD))
    else $error("cycle counter reached the IRQ period");

  a_disabled_is_idle: assert property (@(posedge clk) disable iff (rst)
    !irq_enable |-> (cycle_counter == '0) && !irq_pending)
    else $error("counter or IRQ active while disabled");

  a_enable_tracks_control: assert property (@(posedge clk) disable iff (rst)
    irq_enable == control_latch[0])
    else $error("IRQ enable out of step with control latch");

  a_irq_rises_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_pending) |-> $past(fire) && ($past(item.cmd) == CMD_TICK))
    else $error("IRQ raised without an accepted tick");
`endif

endmodule

`default_nettype wire

>>> rtl/multicart_mapper_irq_bank_logic.sv
// ----------------------------------------------------------------------------
// multicart_mapper_irq_bank_logic
// Flow: an accepted item waits in the input register stage and moves into
//   the result register stage once that stage is free or being drained.
//   Throughput: one item per cycle, sustained while rsp.ready stays high.
//   Reset (rst, synchronous, active high) clears the valid flags of both
//   register stages, the bank and control latches, the IRQ enable, the
//   cycle counter and the IRQ.
// Mapper for a 4-in-1 multicart: bank latch, control latch and a CPU-cycle
// interrupt counter, one result per bus item.
// ----------------------------------------------------------------------------
`default_nettype none

module multicart_mapper_irq_bank_logic (
  input  wire logic   clk,
  input  wire logic   rst,
  mcirq_in_if.sink    req,
  mcirq_out_if.source rsp
);
  import mcirq_pkg::*;

  // Input register stage
  logic    in_valid;
  item_t   in_item;

  // Result register stage
  logic    out_valid;
  result_t out_res;

  result_t result;
  logic    advance;

  // Move the held item into the result stage whenever that stage is free
  // or being drained this cycle; the state update rides on the same edge.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  // Payload: load on every accepted item, hold otherwise
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.cmd    <= req.cmd;
      in_item.addr   <= req.addr;
      in_item.wdata  <= req.wdata;
      in_item.cycles <= req.cycles;
    end
  end

  // Decode and state update for the held item
  mcirq_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (result)
  );

  // Result stage: fill on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.rdata       = out_res.rdata;
  assign rsp.rdata_valid = out_res.rdata_valid;
  assign rsp.irq         = out_res.irq;
  assign rsp.bank_c000   = out_res.bank_c000;

endmodule

`default_nettype wire
